// ----- hw/rtl/esd_pkg.sv -----
// Shared types and constants for the string escape decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package esd_pkg;

  // Request moved on the input channel: one raw byte of the literal body.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } esd_in_t;

  // Request moved on the output channel: one decoded byte plus status.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_end;
    logic       string_end;
  } esd_out_t;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_HEX   = 2'd2;
  localparam logic [1:0] ST_UNK   = 2'd3;

  // Decoder modes
  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_ESC   = 3'd1;
  localparam logic [2:0] MODE_HEX1  = 3'd2;
  localparam logic [2:0] MODE_HEX2  = 3'd3;
  localparam logic [2:0] MODE_OCT1  = 3'd4;
  localparam logic [2:0] MODE_OCT2  = 3'd5;

  // Characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Hex digit value; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (b inside {[CH_0:CH_9]}) begin
        t = b - CH_0;
      end else if (b inside {[CH_LA:CH_LF]}) begin
        t = b - CH_LA + 8'd10;
      end else if (b inside {[CH_UA:CH_UF]}) begin
        t = b - CH_UA + 8'd10;
      end else begin
        t = 8'd16;
      end
      hex_value = t[4:0];
    end
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    is_octal = (b inside {[CH_0:CH_7]});
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/esd_decode.sv -----
// Escape decode step: mode/partial-value state and up to two results per byte.
// Depends on esd_pkg.
`default_nettype none

module esd_decode
  import esd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,    // commit this byte's state update
  input  wire esd_in_t  req_i,
  output logic [1:0]    cnt_o,     // number of results, 0..2
  output esd_out_t      res0_o,
  output esd_out_t      res1_o
);

  logic [2:0] mode_q, mode_d;
  logic [7:0] part_q, part_d;

  logic [7:0] b;
  logic       last;
  logic [4:0] hv;
  logic [7:0] oct_val;

  // plain-text handling of the current byte
  logic       p_emit;
  logic [2:0] p_mode;
  logic [7:0] p_byte;
  logic [1:0] p_st;

  logic [7:0] e0_byte, e1_byte;
  logic [1:0] e0_st, e1_st;
  logic [1:0] n;

  assign b       = req_i.in_byte;
  assign last    = req_i.in_last;
  assign hv      = hex_value(b);
  assign oct_val = {part_q[4:0], b[2:0]};

  always_comb begin
    p_emit = 1'b1;
    p_mode = MODE_PLAIN;
    p_byte = b;
    p_st   = ST_OK;
    if (b == CH_BSLASH) begin
      p_byte = 8'd0;
      if (last) begin
        p_st = ST_SHORT;
      end else begin
        p_emit = 1'b0;
        p_mode = MODE_ESC;
      end
    end
  end

  always_comb begin
    mode_d  = MODE_PLAIN;
    part_d  = part_q;
    n       = 2'd0;
    e0_byte = 8'd0;
    e0_st   = ST_OK;
    e1_byte = 8'd0;
    e1_st   = ST_OK;
    case (mode_q)
      MODE_ESC: begin
        n = 2'd1;
        case (b)
          CH_LA:     e0_byte = 8'd7;
          CH_LB:     e0_byte = 8'd8;
          CH_LF:     e0_byte = 8'd12;
          CH_LN:     e0_byte = 8'd10;
          CH_LR:     e0_byte = 8'd13;
          CH_LT:     e0_byte = 8'd9;
          CH_LV:     e0_byte = 8'd11;
          CH_BSLASH: e0_byte = CH_BSLASH;
          CH_QUOTE:  e0_byte = CH_QUOTE;
          CH_DQUOTE: e0_byte = CH_DQUOTE;
          CH_X: begin
            if (last) begin
              e0_st = ST_SHORT;
            end else begin
              n      = 2'd0;
              mode_d = MODE_HEX1;
            end
          end
          default: begin
            if (is_octal(b)) begin
              part_d  = {5'd0, b[2:0]};
              e0_byte = {5'd0, b[2:0]};
              if (!last) begin
                n      = 2'd0;
                mode_d = MODE_OCT1;
              end
            end else begin
              e0_st = ST_UNK;
            end
          end
        endcase
      end
      MODE_HEX1: begin
        if (hv[4]) begin
          n     = 2'd1;
          e0_st = ST_HEX;
        end else if (last) begin
          n     = 2'd1;
          e0_st = ST_SHORT;
        end else begin
          part_d = {hv[3:0], 4'd0};
          mode_d = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        n = 2'd1;
        if (hv[4]) begin
          e0_st = ST_HEX;
        end else begin
          e0_byte = {part_q[7:4], hv[3:0]};
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_octal(b)) begin
          part_d = oct_val;
          if (mode_q == MODE_OCT2 || last) begin
            n       = 2'd1;
            e0_byte = oct_val;
          end else begin
            mode_d = MODE_OCT2;
          end
        end else begin
          // run ended by a non-octal byte: flush value, then treat byte as text
          e0_byte = part_q;
          e1_byte = p_byte;
          e1_st   = p_st;
          n       = p_emit ? 2'd2 : 2'd1;
          mode_d  = p_mode;
        end
      end
      default: begin
        n       = {1'b0, p_emit};
        e0_byte = p_byte;
        e0_st   = p_st;
        mode_d  = p_mode;
      end
    endcase
    if (mode_d == MODE_PLAIN || last) begin
      mode_d = MODE_PLAIN;
      part_d = 8'd0;
    end
  end

  always_comb begin
    cnt_o             = n;
    res0_o.out_byte   = e0_byte;
    res0_o.status     = e0_st;
    res0_o.run_end    = (n == 2'd1);
    res0_o.string_end = (n == 2'd1) && last;
    res1_o.out_byte   = e1_byte;
    res1_o.status     = e1_st;
    res1_o.run_end    = 1'b1;
    res1_o.string_end = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      part_q <= 8'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/esd_outbuf.sv -----
// Two-entry result buffer: takes up to two results a cycle as room allows, gives one unless the output stalls.
// Depends on esd_pkg.
`default_nettype none

module esd_outbuf
  import esd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire esd_out_t push0_i,
  input  wire esd_out_t push1_i,
  output logic [1:0]    room_o,     // free slots counting this cycle's pop
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output esd_out_t      out_req_o
);

  esd_out_t   slot_q [2];
  esd_out_t   slot_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign base        = cnt_q - {1'b0, pop};
  assign room_o      = 2'd2 - base;

  always_comb begin
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    if (push_cnt_i != 2'd0) begin
      slot_d[base[0]] = push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      slot_d[1] = push1_i;
    end
    cnt_d = base + push_cnt_i;
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/string_escape_decoder_core.sv -----
// C string escape decoder, top level. Depends on esd_pkg, esd_decode, esd_outbuf.
// Path: an accepted input request passes the input register, then the result
// buffer, before its first result can be taken.
// Throughput: one input request per cycle; an octal run closed by another
// byte yields two results, and the input stalls while the buffer lacks room.
// Reset (async, active low): plain-text mode, partial value 0, buffers empty.
`default_nettype none

module string_escape_decoder_core
  import esd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire esd_in_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output esd_out_t      out_req_o
);

  // Input register: holds one request until the decode step can commit it.
  logic     in_vld_q;
  esd_in_t  in_req_q;

  logic [1:0] res_cnt;
  esd_out_t   res0, res1;
  logic [1:0] room;
  logic       step;
  logic       accept;

  // The step commits once the result buffer has room for every result
  // this byte produces (zero results always fits).
  assign step       = in_vld_q && (room >= res_cnt);
  // Stall while the held request cannot commit; a committing request frees
  // the register, so a new one is taken in the same cycle.
  assign in_stall_o = in_vld_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
  end

  // Decode: escape state machine, one byte per step.
  esd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .cnt_o  (res_cnt),
    .res0_o (res0),
    .res1_o (res1)
  );

  // Result buffer decouples the decoder from output stalls.
  esd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (step ? res_cnt : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for string_escape_decoder_core.
// Depends on esd_pkg and the decoder RTL; a built-in predictor decodes every
// accepted request and checks each result in order.
`timescale 1ns / 100ps

module testbench
  import esd_pkg::*;
();

  localparam int PHASE_ITEMS = 250;   // least number of random requests per random phase
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 8;     // extra wait after the last expected result, to catch strays

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    logic       typed;   // expected result given in the row itself
    esd_out_t   want;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  esd_in_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  esd_out_t out_req_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  // predictor state
  logic [2:0] dec_mode = MODE_PLAIN;
  logic [7:0] dec_partial = 8'h00;

  esd_out_t step_results[$];  // results of the request just decoded
  esd_out_t due_results[$];   // results expected from the block, oldest first
  esd_in_t  stim_q[$];
  dir_row_t dir_q[$];

  string_escape_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] hex_digit_val(input logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return 5'(b - CH_0);
    if (b >= CH_LA && b <= CH_LF) return 5'(b - CH_LA + 8'd10);
    if (b >= CH_UA && b <= CH_UF) return 5'(b - CH_UA + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic octal_digit(input logic [7:0] b);
    return b >= CH_0 && b <= CH_7;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic [1:0] st);
    esd_out_t r;
    r.out_byte   = b;
    r.status     = st;
    r.run_end    = 1'b0;
    r.string_end = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void plain_text_byte(input logic [7:0] b, input logic last);
    dec_mode = MODE_PLAIN;
    if (b != CH_BSLASH) push_result(b, ST_OK);
    else if (last) push_result(8'h00, ST_SHORT);
    else dec_mode = MODE_ESC;
  endfunction

  function automatic void escape_letter(input logic [7:0] b, input logic last);
    dec_mode = MODE_PLAIN;
    case (b)
      CH_LA:     push_result(8'h07, ST_OK);
      CH_LB:     push_result(8'h08, ST_OK);
      CH_LF:     push_result(8'h0C, ST_OK);
      CH_LN:     push_result(8'h0A, ST_OK);
      CH_LR:     push_result(8'h0D, ST_OK);
      CH_LT:     push_result(8'h09, ST_OK);
      CH_LV:     push_result(8'h0B, ST_OK);
      CH_BSLASH: push_result(CH_BSLASH, ST_OK);
      CH_QUOTE:  push_result(CH_QUOTE, ST_OK);
      CH_DQUOTE: push_result(CH_DQUOTE, ST_OK);
      CH_X: begin
        if (last) push_result(8'h00, ST_SHORT);
        else dec_mode = MODE_HEX1;
      end
      default: begin
        if (octal_digit(b)) begin
          dec_partial = {5'd0, b[2:0]};
          if (last) push_result(dec_partial, ST_OK);
          else dec_mode = MODE_OCT1;
        end else begin
          push_result(8'h00, ST_UNK);
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(input esd_in_t r);
    logic [4:0] d;
    step_results = {};
    d = hex_digit_val(r.in_byte);
    case (dec_mode)
      MODE_ESC: escape_letter(r.in_byte, r.in_last);
      MODE_HEX1: begin
        dec_mode = MODE_PLAIN;
        if (d[4]) push_result(8'h00, ST_HEX);
        else if (r.in_last) push_result(8'h00, ST_SHORT);
        else begin
          dec_partial = {d[3:0], 4'h0};
          dec_mode = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        dec_mode = MODE_PLAIN;
        if (d[4]) push_result(8'h00, ST_HEX);
        else push_result(dec_partial | {4'h0, d[3:0]}, ST_OK);
      end
      MODE_OCT1, MODE_OCT2: begin
        if (octal_digit(r.in_byte)) begin
          // value keeps its low 8 bits only
          dec_partial = {dec_partial[4:0], r.in_byte[2:0]};
          if (dec_mode == MODE_OCT2 || r.in_last) begin
            dec_mode = MODE_PLAIN;
            push_result(dec_partial, ST_OK);
          end else begin
            dec_mode = MODE_OCT2;
          end
        end else begin
          // run closed by another byte: value first, then that byte as text
          push_result(dec_partial, ST_OK);
          plain_text_byte(r.in_byte, r.in_last);
        end
      end
      default: plain_text_byte(r.in_byte, r.in_last);
    endcase
    if (dec_mode == MODE_PLAIN || r.in_last) begin
      dec_mode    = MODE_PLAIN;
      dec_partial = 8'h00;
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].run_end    = 1'b1;
      step_results[step_results.size() - 1].string_end = r.in_last;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic dir_row_t mk_row(input logic [7:0] b, input logic last,
                                      input logic typed, input logic [7:0] ob,
                                      input logic [1:0] st);
    dir_row_t row;
    row.in_byte         = b;
    row.in_last         = last;
    row.typed           = typed;
    row.want.out_byte   = ob;
    row.want.status     = st;
    row.want.run_end    = 1'b1;
    row.want.string_end = last;
    return row;
  endfunction

  function automatic logic [7:0] simple_letter(input int k);
    case (k)
      0:       return CH_LA;
      1:       return CH_LB;
      2:       return CH_LF;
      3:       return CH_LN;
      4:       return CH_LR;
      5:       return CH_LT;
      6:       return CH_LV;
      7:       return CH_BSLASH;
      8:       return CH_QUOTE;
      default: return CH_DQUOTE;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return CH_0 + 8'(v);
    return (upper ? CH_UA : CH_LA) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // One string literal body: mostly well-formed escapes with random content,
  // some raw noise, and now and then a body cut short at a random point.
  task automatic build_string();
    logic [7:0] body[$];
    logic [7:0] b;
    logic [4:0] hv;
    esd_in_t    r;
    int         kind;
    int         bad_pos;
    body = {};
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        do b = rand_byte(); while (b == CH_BSLASH);
        body.push_back(b);
      end else if (kind < 45) begin
        body.push_back(CH_BSLASH);
        body.push_back(simple_letter($urandom_range(9)));
      end else if (kind < 65) begin
        body.push_back(CH_BSLASH);
        body.push_back(CH_X);
        repeat (2) body.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      end else if (kind < 85) begin
        body.push_back(CH_BSLASH);
        repeat ($urandom_range(1, 3)) body.push_back(CH_0 + 8'($urandom_range(7)));
      end else if (kind < 92) begin
        // bad hex digit in first or second place
        body.push_back(CH_BSLASH);
        body.push_back(CH_X);
        bad_pos = $urandom_range(1);
        if (bad_pos == 1) body.push_back(hex_char(4'($urandom_range(15)), 1'b0));
        do begin
          b  = rand_byte();
          hv = hex_digit_val(b);
        end while (!hv[4]);
        body.push_back(b);
      end else if (kind < 96) begin
        body.push_back(CH_BSLASH);
        body.push_back(rand_byte());
      end else begin
        body.push_back(rand_byte());
      end
    end
    if ($urandom_range(9) == 0) repeat ($urandom_range(body.size() - 1)) void'(body.pop_back());
    foreach (body[i]) begin
      r.in_byte = body[i];
      r.in_last = (i == body.size() - 1);
      stim_q.push_back(r);
    end
  endtask

  // Drives one request and books its results once the block takes it.
  task automatic send_request(input esd_in_t r, input logic typed, input esd_out_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(r);
    if (typed) due_results.push_back(want);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    esd_out_t none;
    none = '0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stim_q = {};
    while (stim_q.size() < PHASE_ITEMS) build_string();
    foreach (stim_q[i]) send_request(stim_q[i], 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    esd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result %h arrived with nothing outstanding", out_req_o);
        mismatch_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("out_byte", want.out_byte, out_req_o.out_byte);
        check_field("status", want.status, out_req_o.status);
        check_field("run_end", want.run_end, out_req_o.run_end);
        check_field("string_end", want.string_end, out_req_o.string_end);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    esd_in_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes, escapes, error codes, octal corner cases
    dir_q.push_back(mk_row(8'h00,     1'b0, 1'b1, 8'h00, ST_OK));
    dir_q.push_back(mk_row(8'hFF,     1'b1, 1'b1, 8'hFF, ST_OK));
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_LN,     1'b0, 1'b1, 8'h0A, ST_OK));
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_X,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_UF,     1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_LF,     1'b0, 1'b1, 8'hFF, ST_OK));
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_X,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(8'h67,     1'b0, 1'b1, 8'h00, ST_HEX));   // 'g'
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(8'h3F,     1'b0, 1'b1, 8'h00, ST_UNK));   // '?'
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_7,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_7,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_7,      1'b0, 1'b1, 8'hFF, ST_OK));    // 0777 wraps
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_0,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_BSLASH, 1'b1, 1'b0, 8'h00, ST_OK));    // two results
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_X,      1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(8'h31,     1'b1, 1'b1, 8'h00, ST_SHORT)); // '1' ends \x1
    dir_q.push_back(mk_row(CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_OK));
    dir_q.push_back(mk_row(CH_0,      1'b1, 1'b1, 8'h00, ST_OK));    // NUL at end
    dir_q.push_back(mk_row(CH_BSLASH, 1'b1, 1'b1, 8'h00, ST_SHORT));

    foreach (dir_q[i]) begin
      r.in_byte = dir_q[i].in_byte;
      r.in_last = dir_q[i].in_last;
      send_request(r, dir_q[i].typed, dir_q[i].want);
    end

    run_random_phase(0, 0);
    run_random_phase(75, 0);
    run_random_phase(0, 75);
    run_random_phase(31, 31);
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
